// ===== src/ord_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ord_pkg
// Shared widths, codes and types for the output-restricted deque.
// ----------------------------------------------------------------------------
package ord_pkg;

	localparam int ORD_DEPTH_DEFAULT = 16;
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT  = 2'd0,
		CMD_PUSH_REAR   = 2'd1,
		CMD_REMOVE_REAR = 2'd2,
		CMD_READ        = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = '1;

	typedef struct packed {
		logic                      valid;
		status_t                   status;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] rear_value;
		logic [COUNT_W-1:0]        entry_count;
	} ord_res_t;

endpackage
`default_nettype wire

// ===== src/ord_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ord_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ord_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/ord_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ord_ctrl
// Ring pointers, occupancy and end-value cache; drives the entry RAM and
// builds one result per command.
// ----------------------------------------------------------------------------
module ord_ctrl #(
	parameter int DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              take,
	input  wire ord_pkg::cmd_t                     command,
	input  wire logic signed [ord_pkg::VALUE_W-1:0] value,
	output      logic                              busy,
	output      logic                              wr_en,
	output      logic [$clog2(DEPTH)-1:0]          wr_addr,
	output      logic [ord_pkg::VALUE_W-1:0]       wr_data,
	output      logic                              rd_en,
	output      logic [$clog2(DEPTH)-1:0]          rd_addr,
	input  wire logic [ord_pkg::VALUE_W-1:0]       rd_data,
	output      ord_pkg::ord_res_t                 res
);
	import ord_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	typedef enum logic {S_IDLE, S_FETCH} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          front_q, rear_q, front_d, rear_d;
	logic [OCC_W-1:0]          occ_q, occ_d;
	logic signed [VALUE_W-1:0] front_val_q, rear_val_q, front_val_d, rear_val_d;
	status_t                   status_d;
	logic                      need_read;
	logic                      is_push, is_empty, is_full;
	logic [IDX_W-1:0]          front_dec, rear_dec, rear_inc;

	assign is_push   = (command == CMD_PUSH_FRONT) || (command == CMD_PUSH_REAR);
	assign is_empty  = (occ_q == '0);
	assign is_full   = (occ_q == FULL_OCC);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign rear_dec  = (rear_q == '0) ? LAST_IDX : rear_q - 1'b1;
	assign rear_inc  = (rear_q == LAST_IDX) ? '0 : rear_q + 1'b1;

	always_comb begin
		front_d     = front_q;
		rear_d      = rear_q;
		occ_d       = occ_q;
		front_val_d = front_val_q;
		rear_val_d  = rear_val_q;
		status_d    = ST_OK;
		need_read   = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = front_q;
		rd_en       = 1'b0;
		rd_addr     = rear_dec;
		if (is_push) begin
			if (is_full) begin
				status_d = ST_OVERFLOW;
			end else begin
				wr_en = take;
				occ_d = occ_q + 1'b1;
				priority if (is_empty) begin
					rear_d      = front_q;
					front_val_d = value;
					rear_val_d  = value;
				end else if (command == CMD_PUSH_FRONT) begin
					front_d     = front_dec;
					wr_addr     = front_dec;
					front_val_d = value;
				end else begin
					rear_d     = rear_inc;
					wr_addr    = rear_inc;
					rear_val_d = value;
				end
			end
		end else if (command == CMD_REMOVE_REAR) begin
			if (is_empty) begin
				status_d = ST_UNDERFLOW;
			end else begin
				occ_d = occ_q - 1'b1;
				if (occ_q != OCC_W'(1)) begin
					rear_d    = rear_dec;
					need_read = 1'b1;
					rd_en     = take;
				end
			end
		end
	end

	assign wr_data = value;
	assign busy    = (state_q == S_FETCH);

	always_comb begin
		res.entry_count = COUNT_W'(occ_q);
		if (state_q == S_FETCH) begin
			res.valid       = 1'b1;
			res.status      = ST_OK;
			res.front_value = front_val_q;
			res.rear_value  = rd_data;
		end else begin
			res.valid       = take && !need_read;
			res.status      = status_d;
			res.entry_count = COUNT_W'(occ_d);
			res.front_value = (occ_d == '0) ? EMPTY_VALUE : front_val_d;
			res.rear_value  = (occ_d == '0) ? EMPTY_VALUE : rear_val_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			rear_q  <= '0;
			occ_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						front_q <= front_d;
						rear_q  <= rear_d;
						occ_q   <= occ_d;
						if (need_read) begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			rear_val_q <= rd_data;
		end else if (take) begin
			front_val_q <= front_val_d;
			rear_val_q  <= rear_val_d;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("Occupancy exceeds the ring depth.");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("RAM write and read issued in the same cycle.");

	a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_IDLE))
		else $error("Rear fetch did not complete in one cycle.");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !take)
		else $error("Command taken while a rear fetch is pending.");

	a_read_leaves_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (occ_q != '0))
		else $error("Rear fetch issued although the deque becomes empty.");

endmodule
`default_nettype wire

// ===== src/output_restricted_deque_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// output_restricted_deque_top
// Output-restricted deque of signed 32-bit values in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata fields (low bit up)
// s_*      in         command[1:0], value[33:2], zero pad to 40 bits
// m_*      out        status[1:0], front_value[33:2], rear_value[65:34],
//                     entry_count[70:66], zero pad to 72 bits
//
// A push, a read, a rejected command or a removal that empties the deque
// builds its result in the same cycle it is taken. A removal that leaves one
// or more entries passes through S_FETCH, where the new rear entry is read
// from the registered RAM read port; no command is taken until that ends.
// Reset clears the pointers and the count; RAM contents are not cleared.
// A stalled result holds in the output register, and a new command is
// taken in the cycle that result leaves.
// ----------------------------------------------------------------------------
module output_restricted_deque_top #(
	parameter int DEPTH = ord_pkg::ORD_DEPTH_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	// command[1:0], value[33:2]
	input  wire logic [ord_pkg::IN_TDATA_W-1:0]      s_tdata,
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	// status[1:0], front_value[33:2], rear_value[65:34], entry_count[70:66]
	output      logic [ord_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import ord_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	logic                      take, busy;
	cmd_t                      command;
	logic signed [VALUE_W-1:0] value;
	logic                      wr_en, rd_en;
	logic [IDX_W-1:0]          wr_addr, rd_addr;
	logic [VALUE_W-1:0]        wr_data, rd_data;
	ord_res_t                  res;
	ord_res_t                  out_q;
	logic                      out_valid_q;

	assign command  = cmd_t'(s_tdata[CMD_W-1:0]);
	assign value    = s_tdata[CMD_W+VALUE_W-1:CMD_W];
	assign s_tready = !busy && (!out_valid_q || m_tready);
	assign take     = s_tvalid && s_tready;

	ord_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.command (command),
		.value   (value),
		.busy    (busy),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (res)
	);

	ord_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.entry_count, out_q.rear_value,
		out_q.front_value, out_q.status};

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for output_restricted_deque_top. A short scripted run
// covers reset, empty removal, value extremes, a fill to the brim and pushes
// into a full deque. Phases of random commands with different push/remove
// mixes follow. Each accepted command updates a shadow deque, and every result
// transaction is compared against the script row's view or, if that row gives
// none, the shadow's prediction. Both sides idle at random, and the receiver
// stalls once for a long stretch, so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
	import ord_pkg::*;

	localparam int DEPTH        = 16;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int GAP_MAX      = 18;
	localparam int PHASES       = 10;
	localparam int PHASE_LEN    = 125;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int SETTLE_LIMIT = 5000;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] rear_value;
		logic [COUNT_W-1:0]        entry_count;
	} deque_view_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [VALUE_W-1:0] value;
		logic [4:0]         reps;
		logic               typed;
		deque_view_t        view;
	} script_row_t;

	localparam deque_view_t NO_VIEW = '{ST_OK, 32'sd0, 32'sd0, 5'd0};

	localparam script_row_t SCRIPT [13] = '{
		'{CMD_READ,        32'h0000_0000, 5'd1,  1'b1, '{ST_OK, EMPTY_VALUE, EMPTY_VALUE, 5'd0}},
		'{CMD_REMOVE_REAR, 32'h0000_0000, 5'd1,  1'b1,
			'{ST_UNDERFLOW, EMPTY_VALUE, EMPTY_VALUE, 5'd0}},
		'{CMD_PUSH_FRONT,  32'h7FFF_FFFF, 5'd1,  1'b1,
			'{ST_OK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1}},
		'{CMD_PUSH_REAR,   32'h8000_0000, 5'd1,  1'b1,
			'{ST_OK, 32'sh7FFF_FFFF, 32'sh8000_0000, 5'd2}},
		'{CMD_READ,        32'hFFFF_FFFF, 5'd1,  1'b0, NO_VIEW},
		'{CMD_REMOVE_REAR, 32'h0000_0000, 5'd1,  1'b1,
			'{ST_OK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1}},
		'{CMD_REMOVE_REAR, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK, EMPTY_VALUE, EMPTY_VALUE, 5'd0}},
		'{CMD_PUSH_REAR,   32'h0000_0000, 5'd1,  1'b1, '{ST_OK, 32'sd0, 32'sd0, 5'd1}},
		'{CMD_PUSH_FRONT,  32'hFFFF_FFFF, 5'd1,  1'b0, NO_VIEW},
		'{CMD_PUSH_REAR,   32'h5555_5555, 5'd13, 1'b0, NO_VIEW},
		'{CMD_PUSH_FRONT,  32'hAAAA_AAAA, 5'd1,  1'b0, NO_VIEW},
		'{CMD_PUSH_REAR,   32'h1234_5678, 5'd1,  1'b0, NO_VIEW},
		'{CMD_PUSH_FRONT,  32'h0000_0000, 5'd1,  1'b0, NO_VIEW}
	};

	localparam int PUSH_PCT   [PHASES] = '{80, 20, 50, 70, 30, 45, 90, 15, 50, 60};
	localparam int REMOVE_PCT [PHASES] = '{15, 70, 40, 25, 60, 45,  5, 80, 30, 35};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic signed [VALUE_W-1:0] shadow_ring [DEPTH];
	logic [IDX_W-1:0]          shadow_front;
	logic [IDX_W-1:0]          shadow_rear;
	int                        shadow_count;

	deque_view_t deque_views_q [$];

	int tx_mode;
	int rx_mode;
	int error_count;
	int cmd_seen [4];
	int overflow_seen;
	int underflow_seen;
	int peak_fill;
	int wrap_seen;

	output_restricted_deque_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(2_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int draw_gap(input int mode);
		case (mode)
			0: draw_gap = 0;
			1: draw_gap = $urandom_range(0, GAP_MAX);
			default: draw_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : 0;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: pick_value = 32'h7FFF_FFFF;
			1: pick_value = 32'h8000_0000;
			2: pick_value = 32'hFFFF_FFFF;
			3: pick_value = 32'h0000_0000;
			default: pick_value = $urandom();
		endcase
	endfunction

	task automatic apply_command(input cmd_t cmd, input logic signed [VALUE_W-1:0] value,
			output deque_view_t view);
		status_t st;
		st = ST_OK;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (shadow_count == DEPTH) begin
					st = ST_OVERFLOW;
				end else begin
					if (shadow_count == 0) begin
						shadow_rear = shadow_front;
						shadow_ring[shadow_front] = value;
					end else if (cmd == CMD_PUSH_FRONT) begin
						if (shadow_front == '0)
							wrap_seen++;
						shadow_front = shadow_front - 1'b1;
						shadow_ring[shadow_front] = value;
					end else begin
						if (shadow_rear == IDX_W'(DEPTH - 1))
							wrap_seen++;
						shadow_rear = shadow_rear + 1'b1;
						shadow_ring[shadow_rear] = value;
					end
					shadow_count++;
				end
			end
			CMD_REMOVE_REAR: begin
				if (shadow_count == 0) begin
					st = ST_UNDERFLOW;
				end else begin
					if (shadow_count > 1)
						shadow_rear = shadow_rear - 1'b1;
					shadow_count--;
				end
			end
			default: ;
		endcase
		view.status = st;
		if (shadow_count == 0) begin
			view.front_value = EMPTY_VALUE;
			view.rear_value  = EMPTY_VALUE;
		end else begin
			view.front_value = shadow_ring[shadow_front];
			view.rear_value  = shadow_ring[shadow_rear];
		end
		view.entry_count = COUNT_W'(shadow_count);
		if (shadow_count > peak_fill)
			peak_fill = shadow_count;
		if (st == ST_OVERFLOW)
			overflow_seen++;
		if (st == ST_UNDERFLOW)
			underflow_seen++;
		cmd_seen[cmd]++;
	endtask

	task automatic send_command(input cmd_t cmd, input logic [VALUE_W-1:0] value, input int gap,
			input logic typed, input deque_view_t typed_view);
		deque_view_t predicted;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, value, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_command(cmd, value, predicted);
		deque_views_q.push_back(typed ? typed_view : predicted);
		@(negedge clk);
	endtask

	task automatic note_error(input string what, input deque_view_t want, input deque_view_t got);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("%0t ERROR %s: expected st=%0d front=%0d rear=%0d cnt=%0d, got st=%0d front=%0d rear=%0d cnt=%0d",
				$realtime, what, want.status, want.front_value, want.rear_value,
				want.entry_count, got.status, got.front_value, got.rear_value,
				got.entry_count);
	endtask

	// Result side: random pauses, one long stall, and a check of every transaction.
	initial begin : result_side
		int          gap;
		int          received;
		deque_view_t got;
		deque_view_t want;
		m_tready = 1'b0;
		received = 0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (received == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_mode);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got.status      = status_t'(m_tdata[1:0]);
			got.front_value = m_tdata[33:2];
			got.rear_value  = m_tdata[65:34];
			got.entry_count = m_tdata[70:66];
			received++;
			if (deque_views_q.size() == 0) begin
				note_error("result with nothing pending", NO_VIEW, got);
			end else begin
				want = deque_views_q.pop_front();
				if (got.status !== want.status || got.front_value !== want.front_value ||
						got.rear_value !== want.rear_value ||
						got.entry_count !== want.entry_count)
					note_error("result mismatch", want, got);
			end
			@(negedge clk);
		end
	end

	initial begin : command_side
		int   row;
		int   rep;
		int   phase;
		int   item;
		int   pick;
		int   settle;
		cmd_t cmd;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		tx_mode        = 1;
		rx_mode        = 1;
		error_count    = 0;
		overflow_seen  = 0;
		underflow_seen = 0;
		peak_fill      = 0;
		wrap_seen      = 0;
		cmd_seen       = '{0, 0, 0, 0};
		shadow_front   = '0;
		shadow_rear    = '0;
		shadow_count   = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < $size(SCRIPT); row++)
			for (rep = 0; rep < SCRIPT[row].reps; rep++)
				send_command(SCRIPT[row].cmd, SCRIPT[row].value, draw_gap(tx_mode),
					SCRIPT[row].typed, SCRIPT[row].view);

		for (phase = 0; phase < PHASES; phase++) begin
			tx_mode = phase % 3;
			rx_mode = (phase / 3) % 3;
			for (item = 0; item < PHASE_LEN; item++) begin
				pick = $urandom_range(0, 99);
				if (pick < PUSH_PCT[phase])
					cmd = ($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
				else if (pick < PUSH_PCT[phase] + REMOVE_PCT[phase])
					cmd = CMD_REMOVE_REAR;
				else
					cmd = CMD_READ;
				send_command(cmd, pick_value(), draw_gap(tx_mode), 1'b0, NO_VIEW);
			end
		end
		s_tvalid <= 1'b0;

		for (settle = 0; settle < SETTLE_LIMIT && deque_views_q.size() != 0; settle++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (deque_views_q.size() != 0)
			note_error("results never arrived", deque_views_q[0], NO_VIEW);

		$display("Ran %0d push-front, %0d push-rear, %0d remove and %0d read transactions.",
			cmd_seen[CMD_PUSH_FRONT], cmd_seen[CMD_PUSH_REAR], cmd_seen[CMD_REMOVE_REAR],
			cmd_seen[CMD_READ]);
		$display("Saw %0d overflows, %0d underflows, %0d index wraps, peak fill %0d of %0d.",
			overflow_seen, underflow_seen, wrap_seen, peak_fill, DEPTH);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
